@@ rtl/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg: shared types, constants and helpers of the depth texture sampler
// Field widths, operation and register codes, store port structs, and the
// coordinate mapping that turns a scaled coordinate into two texel indexes.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int IDX_W      = 8;                 // texel column / row index
  localparam int SIZE_W     = 9;                 // image size registers
  localparam int COORD_FRAC = 16;                // fraction bits of u and v
  localparam int COORD_W    = COORD_FRAC + 2;    // signed coordinate width
  localparam int COORD_ONE  = 1 << COORD_FRAC;
  localparam int COORD_HALF = 1 << (COORD_FRAC - 1);
  localparam int MAX_SIZE   = 1 << IDX_W;
  localparam int PROD_W     = COORD_FRAC + 1 + SIZE_W;  // clamped coord * size
  localparam int INT_W      = PROD_W - COORD_FRAC + 2;  // signed integer part
  localparam int BANK_AW    = IDX_W - 1 + IDX_W;        // one bank per row parity
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_NEAREST  = 2'd1;
  localparam logic [1:0] OP_BILINEAR = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
  } dts_wr_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr_a;
    logic [BANK_AW-1:0] addr_b;
  } dts_rd_t;

  typedef struct packed {
    logic [IDX_W-1:0]      lo;
    logic [IDX_W-1:0]      hi;
    logic [COORD_FRAC-1:0] frac;
  } dts_axis_t;

  // Zero acts as one, anything above the store size acts as the store size.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] s;
    if (r == '0) begin
      s = SIZE_W'(1);
    end else if (r > SIZE_W'(MAX_SIZE)) begin
      s = SIZE_W'(MAX_SIZE);
    end else begin
      s = r;
    end
    return s;
  endfunction

  // Clamp a signed coordinate to 0..1.
  function automatic logic [COORD_FRAC:0] clamp_coord(
    input logic signed [COORD_W-1:0] c
  );
    logic [COORD_FRAC:0] r;
    if (c < 0) begin
      r = '0;
    end else if (c[COORD_W-2:0] > (COORD_W-1)'(COORD_ONE)) begin
      r = (COORD_FRAC+1)'(COORD_ONE);
    end else begin
      r = c[COORD_FRAC:0];
    end
    return r;
  endfunction

  // Floor the scaled coordinate and clamp both footprint indexes to the edge.
  // Nearest uses one index and no weight.
  function automatic dts_axis_t map_axis(
    input logic [PROD_W-1:0] p,
    input logic [SIZE_W-1:0] n,
    input logic              bilin
  );
    logic signed [PROD_W:0]  f;
    logic signed [INT_W-1:0] i0;
    logic signed [INT_W-1:0] i1;
    logic signed [INT_W-1:0] last;
    dts_axis_t               r;
    f = $signed({1'b0, p});
    if (bilin) begin
      f = f - (PROD_W+1)'(COORD_HALF);
    end
    i0   = INT_W'(f >>> COORD_FRAC);
    i1   = bilin ? i0 + INT_W'(1) : i0;
    last = $signed({{(INT_W-SIZE_W){1'b0}}, n}) - INT_W'(1);
    if (i0 < 0) begin
      r.lo = '0;
    end else if (i0 > last) begin
      r.lo = last[IDX_W-1:0];
    end else begin
      r.lo = i0[IDX_W-1:0];
    end
    if (i1 < 0) begin
      r.hi = '0;
    end else if (i1 > last) begin
      r.hi = last[IDX_W-1:0];
    end else begin
      r.hi = i1[IDX_W-1:0];
    end
    r.frac = bilin ? f[COORD_FRAC-1:0] : '0;
    return r;
  endfunction

endpackage

@@ rtl/dts_bank.sv @@
// ----------------------------------------------------------------------------
// dts_bank: one row-parity bank of the depth store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module dts_bank #(
  parameter int DATA_W = 16
) (
  input  logic                  clk_i,
  input  dts_pkg::dts_wr_t      wr_i,
  input  logic [DATA_W-1:0]     wdata_i,
  input  dts_pkg::dts_rd_t      rd_i,
  output logic [DATA_W-1:0]     rdata_a_o,
  output logic [DATA_W-1:0]     rdata_b_o
);

  logic [DATA_W-1:0] mem_q [2**dts_pkg::BANK_AW];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_a_q <= mem_q[rd_i.addr_a];
      rdata_b_q <= mem_q[rd_i.addr_b];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/depth_texture_sampler.sv @@
// ----------------------------------------------------------------------------
// depth_texture_sampler: nearest and bilinear sampling of an on-chip depth image
// Throughput: one item per cycle unless out_ready_i stalls the output, set by
// the five-stage pipeline around the two-bank store (each bank reads two
// columns of one row per cycle).
// Reset: clears pipeline valids and sets both sizes to 256; the store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module depth_texture_sampler #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dts_pkg::PADDR_W-1:0]   paddr,
  input  logic [dts_pkg::PDATA_W-1:0]   pwdata,
  output logic [dts_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [dts_pkg::IDX_W-1:0]     texel_x_i,
  input  logic [dts_pkg::IDX_W-1:0]     texel_y_i,
  input  logic signed [DEPTH_BITS-1:0]  write_depth_i,
  input  logic signed [dts_pkg::COORD_W-1:0] u_coord_i,
  input  logic signed [dts_pkg::COORD_W-1:0] v_coord_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [DEPTH_BITS-1:0]  sampled_depth_o
);

  localparam int IDX_W  = dts_pkg::IDX_W;
  localparam int SIZE_W = dts_pkg::SIZE_W;
  localparam int FRAC   = dts_pkg::COORD_FRAC;
  localparam int PROD_W = dts_pkg::PROD_W;
  localparam int DIFF_W = DEPTH_BITS + 1;
  localparam int MUL_W  = DIFF_W + FRAC + 1;

  // Configuration registers
  logic [SIZE_W-1:0] width_q, height_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dts_pkg::SIZE_RESET;
      height_q <= dts_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        dts_pkg::REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
        dts_pkg::REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dts_pkg::REG_WIDTH:  prdata = {{(dts_pkg::PDATA_W-SIZE_W){1'b0}}, width_q};
      dts_pkg::REG_HEIGHT: prdata = {{(dts_pkg::PDATA_W-SIZE_W){1'b0}}, height_q};
      default:             prdata = '0;
    endcase
  end

  logic [SIZE_W-1:0] w_eff, h_eff;
  assign w_eff = dts_pkg::eff_size(width_q);
  assign h_eff = dts_pkg::eff_size(height_q);

  // Stage enables: a stage loads when it is empty or the one after it is loading
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5        = !v5_q || out_ready_i;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: clamp and scale the coordinates
  logic [1:0]                  op1_q;
  logic [IDX_W-1:0]            wx1_q, wy1_q;
  logic signed [DEPTH_BITS-1:0] wd1_q;
  logic [PROD_W-1:0]           pu1_q, pv1_q, pu1_d, pv1_d;

  assign pu1_d = PROD_W'(dts_pkg::clamp_coord(u_coord_i)) * PROD_W'(w_eff);
  assign pv1_d = PROD_W'(dts_pkg::clamp_coord(v_coord_i)) * PROD_W'(h_eff);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q <= operation_i;
      wx1_q <= texel_x_i;
      wy1_q <= texel_y_i;
      wd1_q <= write_depth_i;
      pu1_q <= pu1_d;
      pv1_q <= pv1_d;
    end
  end

  // Stage 2: footprint indexes and weights; the store is accessed from here
  dts_pkg::dts_axis_t          ax_d, ay_d;
  logic                        bilin1;
  logic [1:0]                  op2_q;
  logic [IDX_W-1:0]            wx2_q, wy2_q;
  logic signed [DEPTH_BITS-1:0] wd2_q;
  dts_pkg::dts_axis_t          ax2_q, ay2_q;

  assign bilin1 = (op1_q == dts_pkg::OP_BILINEAR);
  assign ax_d   = dts_pkg::map_axis(pu1_q, w_eff, bilin1);
  assign ay_d   = dts_pkg::map_axis(pv1_q, h_eff, bilin1);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      op2_q <= op1_q;
      wx2_q <= wx1_q;
      wy2_q <= wy1_q;
      wd2_q <= wd1_q;
      ax2_q <= ax_d;
      ay2_q <= ay_d;
    end
  end

  // Two banks split by row parity; each reads the left and right column of
  // the row it holds. Writes and reads issue from the same stage, so a read
  // always sees every earlier write.
  logic [DEPTH_BITS-1:0] rd_a [2];
  logic [DEPTH_BITS-1:0] rd_b [2];

  for (genvar p = 0; p < 2; p++) begin : g_bank
    logic [IDX_W-1:0]  row;
    dts_pkg::dts_wr_t  wr;
    dts_pkg::dts_rd_t  rd;

    assign row       = (ay2_q.lo[0] == 1'(p)) ? ay2_q.lo : ay2_q.hi;
    assign rd.en     = en3;
    assign rd.addr_a = {row[IDX_W-1:1], ax2_q.lo};
    assign rd.addr_b = {row[IDX_W-1:1], ax2_q.hi};
    assign wr.en     = en3 && v2_q && (op2_q == dts_pkg::OP_WRITE) && (wy2_q[0] == 1'(p));
    assign wr.addr   = {wy2_q[IDX_W-1:1], wx2_q};

    dts_bank #(
      .DATA_W (DEPTH_BITS)
    ) u_bank (
      .clk_i     (clk_i),
      .wr_i      (wr),
      .wdata_i   (wd2_q),
      .rd_i      (rd),
      .rdata_a_o (rd_a[p]),
      .rdata_b_o (rd_b[p])
    );
  end

  // Stage 3: read data arrives; lerp horizontally along both rows
  logic [1:0]      op3_q;
  logic [FRAC-1:0] fx3_q, fy3_q;
  logic            sel_top3_q, sel_bot3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      op3_q      <= op2_q;
      fx3_q      <= ax2_q.frac;
      fy3_q      <= ay2_q.frac;
      sel_top3_q <= ay2_q.lo[0];
      sel_bot3_q <= ay2_q.hi[0];
    end
  end

  logic signed [DEPTH_BITS-1:0] ta, tb, bc, be;
  logic signed [DIFF_W-1:0]     dtop, dbot;
  logic signed [MUL_W-1:0]      mtop, mbot, stop, sbot;
  logic signed [DEPTH_BITS-1:0] top4_d, bot4_d;

  always_comb begin
    ta     = $signed(rd_a[sel_top3_q]);
    tb     = $signed(rd_b[sel_top3_q]);
    bc     = $signed(rd_a[sel_bot3_q]);
    be     = $signed(rd_b[sel_bot3_q]);
    dtop   = DIFF_W'(tb) - DIFF_W'(ta);
    dbot   = DIFF_W'(be) - DIFF_W'(bc);
    mtop   = MUL_W'(dtop) * $signed({1'b0, fx3_q});
    mbot   = MUL_W'(dbot) * $signed({1'b0, fx3_q});
    stop   = MUL_W'(ta) + (mtop >>> FRAC);
    sbot   = MUL_W'(bc) + (mbot >>> FRAC);
    top4_d = DEPTH_BITS'(stop);
    bot4_d = DEPTH_BITS'(sbot);
  end

  // Stage 4: vertical lerp
  logic [1:0]                   op4_q;
  logic [FRAC-1:0]              fy4_q;
  logic signed [DEPTH_BITS-1:0] top4_q, bot4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      op4_q  <= op3_q;
      fy4_q  <= fy3_q;
      top4_q <= top4_d;
      bot4_q <= bot4_d;
    end
  end

  logic signed [DIFF_W-1:0]     dver;
  logic signed [MUL_W-1:0]      mver, sver;
  logic signed [DEPTH_BITS-1:0] res5_d, res5_q;

  always_comb begin
    dver = DIFF_W'(bot4_q) - DIFF_W'(top4_q);
    mver = MUL_W'(dver) * $signed({1'b0, fy4_q});
    sver = MUL_W'(top4_q) + (mver >>> FRAC);
    case (op4_q)
      dts_pkg::OP_NEAREST,
      dts_pkg::OP_BILINEAR: res5_d = DEPTH_BITS'(sver);
      default:              res5_d = '0;
    endcase
  end

  // Stage 5: output register
  always_ff @(posedge clk_i) begin
    if (en5) begin
      res5_q <= res5_d;
    end
  end

  assign out_valid_o     = v5_q;
  assign sampled_depth_o = res5_q;

endmodule

@@ rtl/dts_checker.sv @@
// ----------------------------------------------------------------------------
// dts_checker: port-level checks of the depth texture sampler
// Output hold under backpressure, input never stalled by an empty output,
// and size register readback.
// ----------------------------------------------------------------------------
module dts_checker #(
  parameter int DEPTH_BITS = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [dts_pkg::PADDR_W-1:0]        paddr,
  input logic [dts_pkg::PDATA_W-1:0]        pwdata,
  input logic [dts_pkg::PDATA_W-1:0]        prdata,
  input logic                               pready,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [DEPTH_BITS-1:0]       sampled_depth_o
);

  localparam int SIZE_W = dts_pkg::SIZE_W;
  localparam int PAD_W  = dts_pkg::PDATA_W - SIZE_W;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sampled_depth_o))
    else $error("result changed while stalled");

  // With no result waiting, the pipeline always takes a transfer.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_width_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == dts_pkg::REG_WIDTH)) ##1
    (psel && !pwrite && (paddr[2] == dts_pkg::REG_WIDTH))
    |-> prdata == {{PAD_W{1'b0}}, $past(pwdata[SIZE_W-1:0])})
    else $error("width readback mismatch");

  a_height_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == dts_pkg::REG_HEIGHT)) ##1
    (psel && !pwrite && (paddr[2] == dts_pkg::REG_HEIGHT))
    |-> prdata == {{PAD_W{1'b0}}, $past(pwdata[SIZE_W-1:0])})
    else $error("height readback mismatch");

endmodule

bind depth_texture_sampler dts_checker #(.DEPTH_BITS(DEPTH_BITS)) u_dts_checker (.*);
